// ===== design/lpr_pkg.sv =====
`default_nettype none

package lpr_pkg;

  localparam int COORD_W  = 12;
  localparam int ERR_W    = 13;
  localparam int COLOUR_W = 32;
  localparam int STEP_W   = 4;
  localparam int MOVE_W   = 2;

  localparam int DEF_SCREEN_WIDTH  = 480;
  localparam int DEF_SCREEN_HEIGHT = 270;

  typedef logic [COORD_W-1:0]  coord_t;
  typedef logic [COLOUR_W-1:0] colour_t;
  typedef logic [STEP_W-1:0]   step_t;
  typedef logic [MOVE_W-1:0]   move_t;

  typedef enum logic [0:0] {
    FUNC_START   = 1'b0,
    FUNC_ADVANCE = 1'b1
  } func_t;

  // two-bit two's complement moves
  localparam move_t MOVE_NONE = 2'b00;
  localparam move_t MOVE_INC  = 2'b01;
  localparam move_t MOVE_DEC  = 2'b11;

  // line parameters worked out from a start item
  typedef struct packed {
    coord_t x1;
    coord_t y1;
    coord_t short_len;
    coord_t long_len;
    step_t  par_step;
    step_t  diag_step;
  } line_setup_t;

  function automatic coord_t apply_move(input coord_t coord, input move_t mv);
    coord_t res;
    res = coord;
    case (mv)
      MOVE_INC: res = coord + coord_t'(1);
      MOVE_DEC: res = coord - coord_t'(1);
      default:  res = coord;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== design/lpr_in_if.sv =====
`default_nettype none

interface lpr_in_if;
  import lpr_pkg::*;

  logic    valid;
  logic    ready;
  func_t   func;
  coord_t  start_x;
  coord_t  start_y;
  coord_t  end_x;
  coord_t  end_y;
  colour_t colour;

  modport source (
    output valid, func, start_x, start_y, end_x, end_y, colour,
    input  ready
  );

  modport sink (
    input  valid, func, start_x, start_y, end_x, end_y, colour,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/lpr_out_if.sv =====
`default_nettype none

interface lpr_out_if;
  import lpr_pkg::*;

  logic    valid;
  logic    ready;
  coord_t  pixel_x;
  coord_t  pixel_y;
  colour_t pixel_colour;
  logic    last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, pixel_colour, last_pixel,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, pixel_colour, last_pixel,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/lpr_setup.sv =====
`default_nettype none

module lpr_setup #(
  parameter int SCREEN_WIDTH  = lpr_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = lpr_pkg::DEF_SCREEN_HEIGHT
) (
  input  lpr_pkg::coord_t      start_x,
  input  lpr_pkg::coord_t      start_y,
  input  lpr_pkg::coord_t      end_x,
  input  lpr_pkg::coord_t      end_y,
  output lpr_pkg::line_setup_t setup
);
  import lpr_pkg::*;

  localparam logic [COORD_W:0] W_LIM = (COORD_W+1)'(SCREEN_WIDTH);
  localparam logic [COORD_W:0] H_LIM = (COORD_W+1)'(SCREEN_HEIGHT);
  localparam coord_t X_MAX = COORD_W'(SCREEN_WIDTH - 1);
  localparam coord_t Y_MAX = COORD_W'(SCREEN_HEIGHT - 1);

  coord_t x1, y1, x2, y2;
  coord_t dx, dy;
  move_t  sx, sy;

  // clamp endpoints onto the screen
  assign x1 = ({1'b0, start_x} >= W_LIM) ? X_MAX : start_x;
  assign y1 = ({1'b0, start_y} >= H_LIM) ? Y_MAX : start_y;
  assign x2 = ({1'b0, end_x}   >= W_LIM) ? X_MAX : end_x;
  assign y2 = ({1'b0, end_y}   >= H_LIM) ? Y_MAX : end_y;

  assign dx = (x2 >= x1) ? (x2 - x1) : (x1 - x2);
  assign dy = (y2 >= y1) ? (y2 - y1) : (y1 - y2);

  assign sx = (x2 > x1) ? MOVE_INC : ((x2 < x1) ? MOVE_DEC : MOVE_NONE);
  assign sy = (y2 > y1) ? MOVE_INC : ((y2 < y1) ? MOVE_DEC : MOVE_NONE);

  // a tie goes to the y axis
  always_comb begin
    setup.x1        = x1;
    setup.y1        = y1;
    setup.diag_step = {sy, sx};
    if (dx > dy) begin
      setup.par_step  = {MOVE_NONE, sx};
      setup.short_len = dy;
      setup.long_len  = dx;
    end else begin
      setup.par_step  = {sy, MOVE_NONE};
      setup.short_len = dx;
      setup.long_len  = dy;
    end
  end

endmodule

`default_nettype wire

// ===== design/line_pixel_rasterizer_core.sv =====
`default_nettype none

// channel   dir  handshake     payload
// in_ch     in   valid/ready   func, start_x, start_y, end_x, end_y, colour
// out_ch    out  valid/ready   pixel_x, pixel_y, pixel_colour, last_pixel
//
// one item per cycle while the output is not stalled: the line state steps as the item
// is taken and the pixel lands in the output register on the same edge, so it shows in the next cycle
// in_ch.ready is high whenever the output register is empty or being drained,
// so a stalled output holds one pixel and blocks further items
// synchronous active-low reset clears the line state and the output valid
// an advance item while no line is running is taken and yields no pixel

module line_pixel_rasterizer_core #(
  parameter int SCREEN_WIDTH  = lpr_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = lpr_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic         clk,
  input  logic         rst_n,
  lpr_in_if.sink       in_ch,
  lpr_out_if.source    out_ch
);
  import lpr_pkg::*;

  // line state
  logic                    active_r;
  coord_t                  cur_x_r, cur_y_r;
  logic signed [ERR_W-1:0] error_r;
  coord_t                  short_r, long_r, steps_r;
  step_t                   par_step_r, diag_step_r;
  colour_t                 colour_r;

  // output register
  logic    out_valid_r;
  coord_t  out_x_r, out_y_r;
  colour_t out_colour_r;
  logic    out_last_r;

  line_setup_t             setup;
  logic                    in_ready;
  logic                    accept;
  logic                    is_start;
  logic signed [ERR_W-1:0] err_sub;
  logic                    diag;
  logic signed [ERR_W-1:0] err_adv;
  step_t                   move;
  coord_t                  x_adv, y_adv;
  coord_t                  steps_dec;

  lpr_setup #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_setup (
    .start_x (in_ch.start_x),
    .start_y (in_ch.start_y),
    .end_x   (in_ch.end_x),
    .end_y   (in_ch.end_y),
    .setup   (setup)
  );

  // output register frees up when empty or being taken
  assign in_ready    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;
  assign is_start    = (in_ch.func == FUNC_START);

  // one bresenham step: a negative error means a diagonal move
  assign err_sub   = error_r - $signed({1'b0, short_r});
  assign diag      = err_sub[ERR_W-1];
  assign err_adv   = diag ? (err_sub + $signed({1'b0, long_r})) : err_sub;
  assign move      = diag ? diag_step_r : par_step_r;
  assign x_adv     = apply_move(cur_x_r, move[MOVE_W-1:0]);
  assign y_adv     = apply_move(cur_y_r, move[STEP_W-1:MOVE_W]);
  assign steps_dec = steps_r - coord_t'(1);

  // state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      error_r     <= '0;
      short_r     <= '0;
      long_r      <= '0;
      steps_r     <= '0;
      par_step_r  <= '0;
      diag_step_r <= '0;
      colour_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept && is_start) begin
        // a start drops any running line
        active_r    <= (setup.long_len != '0);
        cur_x_r     <= setup.x1;
        cur_y_r     <= setup.y1;
        error_r     <= $signed({2'b00, setup.long_len[COORD_W-1:1]});
        short_r     <= setup.short_len;
        long_r      <= setup.long_len;
        steps_r     <= setup.long_len;
        par_step_r  <= setup.par_step;
        diag_step_r <= setup.diag_step;
        colour_r    <= in_ch.colour;
        out_valid_r <= 1'b1;
      end else if (accept && active_r) begin
        active_r    <= (steps_dec != '0);
        cur_x_r     <= x_adv;
        cur_y_r     <= y_adv;
        error_r     <= err_adv;
        steps_r     <= steps_dec;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // pixel payload, loaded alongside the valid
  always_ff @(posedge clk) begin
    if (accept && is_start) begin
      out_x_r      <= setup.x1;
      out_y_r      <= setup.y1;
      out_colour_r <= in_ch.colour;
      out_last_r   <= (setup.long_len == '0);
    end else if (accept && active_r) begin
      out_x_r      <= x_adv;
      out_y_r      <= y_adv;
      out_colour_r <= colour_r;
      out_last_r   <= (steps_dec == '0);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel_x      = out_x_r;
  assign out_ch.pixel_y      = out_y_r;
  assign out_ch.pixel_colour = out_colour_r;
  assign out_ch.last_pixel   = out_last_r;

endmodule

`default_nettype wire

// ===== design/lpr_checker.sv =====
`default_nettype none

module lpr_checker (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            in_valid,
  input wire logic            in_ready,
  input wire logic            in_func,
  input wire lpr_pkg::coord_t in_start_x,
  input wire lpr_pkg::coord_t in_start_y,
  input wire lpr_pkg::coord_t in_end_x,
  input wire lpr_pkg::coord_t in_end_y,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire lpr_pkg::coord_t out_pixel_x,
  input wire lpr_pkg::coord_t out_pixel_y,
  input wire lpr_pkg::colour_t out_pixel_colour,
  input wire logic            out_last_pixel
);
  import lpr_pkg::*;

  logic start_acc;
  assign start_acc = in_valid && in_ready && (in_func == FUNC_START);

  // a stalled pixel holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_x)
      && $stable(out_pixel_y) && $stable(out_pixel_colour)
      && $stable(out_last_pixel))
    else $error("pixel changed while stalled");

  // nothing left over from before reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("pixel valid after reset");

  // every start gives its first pixel in the next cycle
  a_start_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    start_acc |=> out_valid)
    else $error("start without first pixel");

  // equal endpoints make a one-pixel line
  a_single_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    start_acc && (in_start_x == in_end_x) && (in_start_y == in_end_y)
      |=> out_last_pixel)
    else $error("single-pixel line not flagged last");

endmodule

bind line_pixel_rasterizer_core lpr_checker u_lpr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_func          (in_ch.func),
  .in_start_x       (in_ch.start_x),
  .in_start_y       (in_ch.start_y),
  .in_end_x         (in_ch.end_x),
  .in_end_y         (in_ch.end_y),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_pixel_x      (out_ch.pixel_x),
  .out_pixel_y      (out_ch.pixel_y),
  .out_pixel_colour (out_ch.pixel_colour),
  .out_last_pixel   (out_ch.last_pixel)
);

`default_nettype wire
